### hw/rtl/jkv_pkg.sv
// ----------------------------------------------------------------------------
// jkv_pkg: shared types and constants for the JSON key/value extractor
// Phase codes, result kinds, character constants and the result record.
// ----------------------------------------------------------------------------
package jkv_pkg;

    localparam int KEY_MAX_DEF   = 16;
    localparam int DEPTH_MAX_DEF = 255;
    localparam int COUNT_MAX_DEF = 65535;

    localparam logic [3:0] P_SEARCH = 4'd0;
    localparam logic [3:0] P_COLON  = 4'd1;
    localparam logic [3:0] P_PRE    = 4'd2;
    localparam logic [3:0] P_STR    = 4'd3;
    localparam logic [3:0] P_TRUE   = 4'd4;
    localparam logic [3:0] P_FALSE  = 4'd5;
    localparam logic [3:0] P_OBJ    = 4'd6;
    localparam logic [3:0] P_ARR    = 4'd7;
    localparam logic [3:0] P_EACH   = 4'd8;
    localparam logic [3:0] P_DONE   = 4'd9;

    localparam logic [1:0] W_TOP  = 2'd0;
    localparam logic [1:0] W_STR  = 2'd1;
    localparam logic [1:0] W_SKIP = 2'd2;
    localparam logic [1:0] W_OBJ  = 2'd3;

    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_END   = 2'd1;
    localparam logic [1:0] K_FINAL = 2'd2;

    localparam logic [2:0] M_STRING = 3'd0;
    localparam logic [2:0] M_BOOL   = 3'd1;
    localparam logic [2:0] M_OBJECT = 3'd2;
    localparam logic [2:0] M_ARRAY  = 3'd3;
    localparam logic [2:0] M_EACH   = 3'd4;

    localparam logic [2:0] R_MODE  = 3'd0;
    localparam logic [2:0] R_KLEN  = 3'd1;
    localparam logic [2:0] R_KEY0  = 3'd2;
    localparam logic [2:0] R_KEY1  = 3'd3;
    localparam logic [2:0] R_FALLB = 3'd4;

    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_BSL   = 8'h5C;
    localparam logic [7:0] C_LBRC  = 8'h7B;
    localparam logic [7:0] C_RBRC  = 8'h7D;
    localparam logic [7:0] C_LBRK  = 8'h5B;
    localparam logic [7:0] C_RBRK  = 8'h5D;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] item_index;
        logic        found;
        logic        bool_value;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == C_SP) || (c == C_TAB) || (c == C_LF) || (c == C_CR);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == 8'h6E) r = C_LF;
        else if (c == 8'h74) r = C_TAB;
        else if (c == 8'h72) r = C_CR;
        return r;
    endfunction

    function automatic logic [7:0] lit_char(input logic is_true, input logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        if (is_true) begin
            case (pos)
                3'd0: r = 8'h74;
                3'd1: r = 8'h72;
                3'd2: r = 8'h75;
                3'd3: r = 8'h65;
                default: r = 8'h00;
            endcase
        end else begin
            case (pos)
                3'd0: r = 8'h66;
                3'd1: r = 8'h61;
                3'd2: r = 8'h6C;
                3'd3: r = 8'h73;
                3'd4: r = 8'h65;
                default: r = 8'h00;
            endcase
        end
        return r;
    endfunction

endpackage

### hw/rtl/jkv_match_cell.sv
// ----------------------------------------------------------------------------
// jkv_match_cell: one stage of the key window
// Holds one recent byte, passes it on, and compares its input with its needle byte.
// ----------------------------------------------------------------------------
module jkv_match_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic       clear,
    input  logic [7:0] byte_in,
    input  logic [7:0] needle,
    input  logic       in_use,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else if (clear)
        begin
            byte_reg <= 8'h00;
        end
        else if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    // compare the byte entering this cell, i.e. the window after the shift
    assign hit      = !in_use || (byte_in == needle);

endmodule

### hw/rtl/jkv_value_walk.sv
// ----------------------------------------------------------------------------
// jkv_value_walk: phase sequencer and value walker
// Tracks strings, depths and items, and builds up to three results per byte.
// ----------------------------------------------------------------------------
module jkv_value_walk #(
    parameter int DEPTH_MAX = jkv_pkg::DEPTH_MAX_DEF,
    parameter int COUNT_MAX = jkv_pkg::COUNT_MAX_DEF,
    parameter int DW        = (DEPTH_MAX < 2) ? 1 : $clog2(DEPTH_MAX + 1),
    parameter int CW        = (COUNT_MAX < 2) ? 1 : $clog2(COUNT_MAX + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          c,
    input  logic                last,
    input  logic                needle_hit,
    input  logic [2:0]          mode,
    input  logic                bool_fallback,
    output logic                search_shift,
    output logic                search_clear,
    output logic                resume,
    output logic [1:0]          n_res,
    output jkv_pkg::result_t    res0,
    output jkv_pkg::result_t    res1,
    output jkv_pkg::result_t    res2
);

    localparam logic [DW-1:0] DMAX = DW'(DEPTH_MAX);
    localparam logic [CW-1:0] CMAX = CW'(COUNT_MAX);

    logic [3:0]    phase_reg, phase_next;
    logic [DW-1:0] od_reg, od_next, id_reg, id_next;
    logic          ob_reg, ob_next, ib_reg, ib_next;
    logic          ins_reg, ins_next, esc_reg, esc_next;
    logic [CW-1:0] items_reg, items_next;
    logic [2:0]    lit_reg, lit_next;
    logic [1:0]    walk_reg, walk_next;
    logic          fnd_reg, fnd_next, bres_reg, bres_next, oend_reg, oend_next;

    jkv_pkg::result_t r [3];
    logic [1:0] cnt;

    always_comb
    begin
        logic structural, ocl, end_mark;
        logic [7:0] op, cl;
        logic [2:0] llen;
        jkv_pkg::result_t e;

        phase_next = phase_reg; od_next = od_reg; id_next = id_reg;
        ob_next = ob_reg; ib_next = ib_reg; ins_next = ins_reg; esc_next = esc_reg;
        items_next = items_reg; lit_next = lit_reg; walk_next = walk_reg;
        fnd_next = fnd_reg; bres_next = bres_reg; oend_next = oend_reg;
        search_shift = 1'b0; search_clear = 1'b0; resume = 1'b0;
        cnt = 2'd0;
        for (int k = 0; k < 3; k++) r[k] = '0;
        structural = 1'b0; ocl = 1'b0; end_mark = 1'b0;
        op = 8'h00; cl = 8'h00; llen = 3'd0;
        e = '0;

        if (c != 8'h00)
        begin
            unique case (phase_reg)
                jkv_pkg::P_SEARCH:
                begin
                    search_shift = 1'b1;
                    if (needle_hit) phase_next = jkv_pkg::P_COLON;
                end
                jkv_pkg::P_COLON:
                begin
                    if (jkv_pkg::is_ws(c)) begin end
                    else if (c == jkv_pkg::C_COLON) phase_next = jkv_pkg::P_PRE;
                    else
                    begin
                        resume = 1'b1;
                        search_shift = 1'b1;
                        phase_next = needle_hit ? jkv_pkg::P_COLON : jkv_pkg::P_SEARCH;
                    end
                end
                jkv_pkg::P_PRE:
                begin
                    if (!jkv_pkg::is_ws(c))
                    begin
                        phase_next = jkv_pkg::P_DONE;
                        case (mode)
                            jkv_pkg::M_STRING:
                                if (c == jkv_pkg::C_QUOTE)
                                begin
                                    fnd_next = 1'b1; ins_next = 1'b1;
                                    phase_next = jkv_pkg::P_STR;
                                end
                            jkv_pkg::M_BOOL:
                                if (c == 8'h74)
                                begin
                                    phase_next = jkv_pkg::P_TRUE; lit_next = 3'd1;
                                end
                                else if (c == 8'h66)
                                begin
                                    phase_next = jkv_pkg::P_FALSE; lit_next = 3'd1;
                                end
                            jkv_pkg::M_OBJECT:
                                if (c == jkv_pkg::C_LBRC)
                                begin
                                    fnd_next = 1'b1; od_next = DW'(1); ob_next = 1'b1;
                                    r[cnt].kind = jkv_pkg::K_BYTE;
                                    r[cnt].out_byte = c;
                                    r[cnt].item_index = 16'(items_reg);
                                    cnt = cnt + 2'd1;
                                    phase_next = jkv_pkg::P_OBJ;
                                end
                            jkv_pkg::M_ARRAY:
                                if (c == jkv_pkg::C_LBRK)
                                begin
                                    fnd_next = 1'b1; od_next = DW'(1); ob_next = 1'b0;
                                    walk_next = jkv_pkg::W_TOP;
                                    phase_next = jkv_pkg::P_ARR;
                                end
                            jkv_pkg::M_EACH:
                                if (c == jkv_pkg::C_LBRC || c == jkv_pkg::C_LBRK)
                                begin
                                    fnd_next = 1'b1; od_next = DW'(1);
                                    ob_next = (c == jkv_pkg::C_LBRC);
                                    walk_next = jkv_pkg::W_TOP;
                                    phase_next = jkv_pkg::P_EACH;
                                end
                            default: begin end
                        endcase
                    end
                end
                jkv_pkg::P_TRUE, jkv_pkg::P_FALSE:
                begin
                    llen = (phase_reg == jkv_pkg::P_TRUE) ? 3'd4 : 3'd5;
                    if (lit_reg >= llen ||
                        c != jkv_pkg::lit_char(phase_reg == jkv_pkg::P_TRUE, lit_reg))
                        phase_next = jkv_pkg::P_DONE;
                    else
                    begin
                        lit_next = lit_reg + 3'd1;
                        if (lit_next == llen)
                        begin
                            fnd_next = 1'b1;
                            bres_next = (phase_reg == jkv_pkg::P_TRUE);
                            phase_next = jkv_pkg::P_DONE;
                        end
                    end
                end
                jkv_pkg::P_STR, jkv_pkg::P_OBJ, jkv_pkg::P_ARR, jkv_pkg::P_EACH:
                begin
                    if (ins_reg)
                    begin
                        if (esc_reg) esc_next = 1'b0;
                        else if (c == jkv_pkg::C_BSL) esc_next = 1'b1;
                        else if (c == jkv_pkg::C_QUOTE) ins_next = 1'b0;
                    end
                    else if (c == jkv_pkg::C_QUOTE) ins_next = 1'b1;
                    structural = !ins_reg && c != jkv_pkg::C_QUOTE;
                    op = ob_reg ? jkv_pkg::C_LBRC : jkv_pkg::C_LBRK;
                    cl = ob_reg ? jkv_pkg::C_RBRC : jkv_pkg::C_RBRK;
                    // outer counter, evaluated once with the old state
                    if (structural && !oend_reg)
                    begin
                        if (c == op)
                        begin
                            if (od_reg < DMAX) od_next = od_reg + DW'(1);
                        end
                        else if (c == cl)
                        begin
                            if (od_reg <= DW'(1))
                            begin
                                od_next = '0; oend_next = 1'b1; ocl = 1'b1;
                            end
                            else od_next = od_reg - DW'(1);
                        end
                    end
                    e.kind = jkv_pkg::K_BYTE;
                    e.item_index = 16'(items_reg);
                    if (phase_reg == jkv_pkg::P_STR)
                    begin
                        if (esc_reg)
                        begin
                            e.out_byte = jkv_pkg::unescape(c); r[0] = e; cnt = 2'd1;
                        end
                        else if (c == jkv_pkg::C_QUOTE)
                        begin
                            end_mark = 1'b1; phase_next = jkv_pkg::P_DONE;
                        end
                        else if (c != jkv_pkg::C_BSL)
                        begin
                            e.out_byte = c; r[0] = e; cnt = 2'd1;
                        end
                    end
                    else if (phase_reg == jkv_pkg::P_OBJ)
                    begin
                        e.out_byte = c; r[0] = e; cnt = 2'd1;
                        if (ocl)
                        begin
                            end_mark = 1'b1; phase_next = jkv_pkg::P_DONE;
                        end
                    end
                    else if (phase_reg == jkv_pkg::P_ARR)
                    begin
                        if (walk_reg == jkv_pkg::W_TOP)
                        begin
                            if (!ins_reg && c == jkv_pkg::C_QUOTE) walk_next = jkv_pkg::W_STR;
                            else if (structural &&
                                     (c == jkv_pkg::C_LBRC || c == jkv_pkg::C_LBRK))
                            begin
                                walk_next = jkv_pkg::W_SKIP; id_next = DW'(1);
                                ib_next = (c == jkv_pkg::C_LBRC);
                            end
                        end
                        else if (walk_reg == jkv_pkg::W_STR)
                        begin
                            if (esc_reg)
                            begin
                                e.out_byte = jkv_pkg::unescape(c); r[0] = e; cnt = 2'd1;
                            end
                            else if (c == jkv_pkg::C_QUOTE)
                            begin
                                end_mark = 1'b1; walk_next = jkv_pkg::W_TOP;
                            end
                            else if (c != jkv_pkg::C_BSL)
                            begin
                                e.out_byte = c; r[0] = e; cnt = 2'd1;
                            end
                        end
                        else if (structural)
                        begin
                            if (c == (ib_reg ? jkv_pkg::C_LBRC : jkv_pkg::C_LBRK))
                            begin
                                if (id_reg < DMAX) id_next = id_reg + DW'(1);
                            end
                            else if (c == (ib_reg ? jkv_pkg::C_RBRC : jkv_pkg::C_RBRK) &&
                                     id_reg != '0)
                                id_next = id_reg - DW'(1);
                            if (id_next == '0) walk_next = jkv_pkg::W_TOP;
                        end
                        if (ocl) phase_next = jkv_pkg::P_DONE;
                    end
                    else
                    begin
                        if (walk_reg == jkv_pkg::W_TOP)
                        begin
                            if (structural && c == jkv_pkg::C_LBRC)
                            begin
                                e.out_byte = c; r[0] = e; cnt = 2'd1;
                                walk_next = jkv_pkg::W_OBJ; id_next = DW'(1); ib_next = 1'b1;
                            end
                        end
                        else
                        begin
                            e.out_byte = c; r[0] = e; cnt = 2'd1;
                            if (structural)
                            begin
                                if (c == (ib_reg ? jkv_pkg::C_LBRC : jkv_pkg::C_LBRK))
                                begin
                                    if (id_reg < DMAX) id_next = id_reg + DW'(1);
                                end
                                else if (c == (ib_reg ? jkv_pkg::C_RBRC : jkv_pkg::C_RBRK) &&
                                         id_reg != '0)
                                    id_next = id_reg - DW'(1);
                                if (id_next == '0)
                                begin
                                    end_mark = 1'b1; walk_next = jkv_pkg::W_TOP;
                                    if (oend_reg) phase_next = jkv_pkg::P_DONE;
                                end
                            end
                        end
                        if (ocl && walk_next != jkv_pkg::W_OBJ) phase_next = jkv_pkg::P_DONE;
                    end
                    if (end_mark)
                    begin
                        r[cnt] = '0;
                        r[cnt].kind = jkv_pkg::K_END;
                        r[cnt].item_index = 16'(items_reg);
                        cnt = cnt + 2'd1;
                        if (items_reg < CMAX) items_next = items_reg + CW'(1);
                    end
                end
                default: begin end
            endcase
        end

        if (c == 8'h00 || last)
        begin
            if (phase_next == jkv_pkg::P_STR ||
                (phase_next == jkv_pkg::P_ARR && walk_next == jkv_pkg::W_STR))
            begin
                if (esc_next)
                begin
                    r[cnt] = '0; r[cnt].kind = jkv_pkg::K_BYTE;
                    r[cnt].out_byte = jkv_pkg::C_BSL;
                    r[cnt].item_index = 16'(items_next);
                    cnt = cnt + 2'd1;
                end
                r[cnt] = '0; r[cnt].kind = jkv_pkg::K_END;
                r[cnt].item_index = 16'(items_next);
                cnt = cnt + 2'd1;
                if (items_next < CMAX) items_next = items_next + CW'(1);
            end
            else if (phase_next == jkv_pkg::P_OBJ ||
                     (phase_next == jkv_pkg::P_EACH && walk_next == jkv_pkg::W_OBJ))
            begin
                r[cnt] = '0; r[cnt].kind = jkv_pkg::K_END;
                r[cnt].item_index = 16'(items_next);
                cnt = cnt + 2'd1;
                if (items_next < CMAX) items_next = items_next + CW'(1);
            end
            r[cnt] = '0; r[cnt].kind = jkv_pkg::K_FINAL;
            r[cnt].item_index = 16'(items_next);
            r[cnt].found = fnd_next;
            r[cnt].bool_value = (mode == jkv_pkg::M_BOOL) ?
                                (fnd_next ? bres_next : bool_fallback) : 1'b0;
            cnt = cnt + 2'd1;
            search_clear = 1'b1;
            phase_next = jkv_pkg::P_SEARCH; od_next = '0; id_next = '0;
            ob_next = 1'b0; ib_next = 1'b0; ins_next = 1'b0; esc_next = 1'b0;
            items_next = '0; lit_next = '0; walk_next = jkv_pkg::W_TOP;
            fnd_next = 1'b0; bres_next = 1'b0; oend_next = 1'b0;
        end
    end

    assign n_res = cnt;
    assign res0  = r[0];
    assign res1  = r[1];
    assign res2  = r[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= jkv_pkg::P_SEARCH; od_reg <= '0; id_reg <= '0;
            ob_reg <= 1'b0; ib_reg <= 1'b0; ins_reg <= 1'b0; esc_reg <= 1'b0;
            items_reg <= '0; lit_reg <= '0; walk_reg <= jkv_pkg::W_TOP;
            fnd_reg <= 1'b0; bres_reg <= 1'b0; oend_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; od_reg <= od_next; id_reg <= id_next;
            ob_reg <= ob_next; ib_reg <= ib_next; ins_reg <= ins_next;
            esc_reg <= esc_next; items_reg <= items_next; lit_reg <= lit_next;
            walk_reg <= walk_next; fnd_reg <= fnd_next; bres_reg <= bres_next;
            oend_reg <= oend_next;
        end
    end

    property p_esc_in_str;
        @(posedge clk) disable iff (!rst_n) esc_reg |-> ins_reg;
    endproperty
    a_esc_in_str: assert property (p_esc_in_str) else $error("escape outside string");

    property p_depth_cap;
        @(posedge clk) disable iff (!rst_n) (od_reg <= DMAX) && (id_reg <= DMAX);
    endproperty
    a_depth_cap: assert property (p_depth_cap) else $error("depth above cap");

    property p_end_clears;
        @(posedge clk) disable iff (!rst_n)
            (step && last) |=> (phase_reg == jkv_pkg::P_SEARCH && items_reg == '0);
    endproperty
    a_end_clears: assert property (p_end_clears) else $error("state kept after end");

endmodule

### hw/rtl/json_key_value_extractor_unit.sv
// ----------------------------------------------------------------------------
// json_key_value_extractor_unit: streaming JSON field extractor
// Finds a quoted key and returns its value in the configured shape.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_axis: one document byte each, tlast marks the last byte
//   (a zero byte also ends the document). Each byte is walked in the same
//   cycle that it is taken. Results leave on m_axis, one word per cycle while
//   the receiver is ready; a byte causes up to three results, tlast set on
//   the last of them. The key window is a chain of 18 byte cells that shift
//   with each byte taken while searching and compare in parallel. Results
//   are written into the result queue as the byte is taken. Input flows at
//   one byte per cycle while each byte makes at most one result and the
//   receiver keeps up. A four-entry result queue decouples the sides: the
//   input is taken while three entries are free once this cycle's output
//   word has left, so a stalled receiver backs up input. Reset clears the
//   walk state, the window and the queue; registers go to 0. The user writes
//   registers on cfg_we with cfg_index only while idle; unchecked by the block.
// ----------------------------------------------------------------------------
module json_key_value_extractor_unit #(
    parameter int KEY_MAX   = jkv_pkg::KEY_MAX_DEF,
    parameter int DEPTH_MAX = jkv_pkg::DEPTH_MAX_DEF,
    parameter int COUNT_MAX = jkv_pkg::COUNT_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    input  logic        s_axis_tlast,   // doc_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_byte, item_index, found, bool_value, pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // run_last
);

    localparam int WIN = KEY_MAX + 2;
    localparam int LW  = $clog2(WIN + 1);

    logic [2:0]   mode_reg;
    logic [4:0]   klen_reg;
    logic [127:0] key_reg;
    logic         fb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0; klen_reg <= '0; key_reg <= '0; fb_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jkv_pkg::R_MODE:  mode_reg <= cfg_data[2:0];
                jkv_pkg::R_KLEN:  klen_reg <= cfg_data[4:0];
                jkv_pkg::R_KEY0:  key_reg[63:0] <= cfg_data;
                jkv_pkg::R_KEY1:  key_reg[127:64] <= cfg_data;
                jkv_pkg::R_FALLB: fb_reg <= cfg_data[0];
                default: begin end
            endcase
        end
    end

    logic step;
    logic search_shift, search_clear, resume;
    logic [1:0] n_res;
    jkv_pkg::result_t res0, res1, res2;

    // needle length and window
    logic [LW-1:0] len;
    assign len = (klen_reg > 5'(KEY_MAX)) ? LW'(KEY_MAX + 2) : LW'(klen_reg) + LW'(2);

    logic [7:0] chain [WIN+1];
    logic [WIN-1:0] hits;
    assign chain[0] = s_axis_tdata;

    // cell j holds the byte j places back; needle index i = len-1-j
    for (genvar j = 0; j < WIN; j++)
    begin : g_cell
        logic [LW-1:0] ni;
        logic [7:0]    nb;
        logic [3:0]    kk;
        assign ni = len - LW'(1) - LW'(j);
        assign kk = 4'(ni - LW'(1));
        assign nb = (ni == '0 || ni == len - LW'(1)) ? jkv_pkg::C_QUOTE :
                    key_reg[{kk, 3'b000} +: 8];
        jkv_match_cell u_cell (
            .clk(clk), .rst_n(rst_n),
            .shift(step && search_shift), .clear(step && search_clear),
            .byte_in(chain[j]), .needle(nb), .in_use(LW'(j) < len),
            .byte_out(chain[j+1]), .hit(hits[j])
        );
    end

    logic [LW-1:0] since_reg, since_next;
    always_comb
    begin
        since_next = resume ? '0 : since_reg;
        if (since_next < LW'(WIN)) since_next = since_next + LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) since_reg <= '0;
        else if (step && search_clear) since_reg <= '0;
        else if (step && search_shift) since_reg <= since_next;
    end

    logic needle_hit;
    assign needle_hit = (since_next >= len) && (&hits);

    jkv_value_walk #(.DEPTH_MAX(DEPTH_MAX), .COUNT_MAX(COUNT_MAX)) u_walk (
        .clk(clk), .rst_n(rst_n), .step(step), .c(s_axis_tdata),
        .last(s_axis_tlast), .needle_hit(needle_hit), .mode(mode_reg),
        .bool_fallback(fb_reg), .search_shift(search_shift),
        .search_clear(search_clear), .resume(resume), .n_res(n_res),
        .res0(res0), .res1(res1), .res2(res2)
    );

    // result queue
    typedef struct packed {
        jkv_pkg::result_t r;
        logic             last;
    } qent_t;

    qent_t      q_mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       pop;

    assign s_axis_tready = (cnt_reg <= 3'd1) || (cnt_reg == 3'd2 && pop);
    assign step          = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (n_res >= 2'd1) q_mem[wp_reg]        <= '{res0, n_res == 2'd1};
            if (n_res >= 2'd2) q_mem[wp_reg + 2'd1] <= '{res1, n_res == 2'd2};
            if (n_res == 2'd3) q_mem[wp_reg + 2'd2] <= '{res2, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (step) wp_reg <= wp_reg + n_res;
            if (pop) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + (step ? {1'b0, n_res} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    qent_t head;
    assign head          = q_mem[rp_reg];
    assign m_axis_tvalid = (cnt_reg != 3'd0);
    assign m_axis_tuser  = head.r.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {6'd0, head.r.bool_value, head.r.found,
                            head.r.item_index, head.r.out_byte};

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("result queue overflow");

    property p_ready_room;
        @(posedge clk) disable iff (!rst_n)
            s_axis_tready |-> (cnt_reg - (pop ? 3'd1 : 3'd0)) <= 3'd1;
    endproperty
    a_ready_room: assert property (p_ready_room) else $error("ready without room");

    property p_final_last;
        @(posedge clk) disable iff (!rst_n)
            (m_axis_tvalid && m_axis_tuser == jkv_pkg::K_FINAL) |-> m_axis_tlast;
    endproperty
    a_final_last: assert property (p_final_last) else $error("final not last");

endmodule

### tb/sv/json_key_value_extractor_unit_tb.sv
// ----------------------------------------------------------------------------
// json_key_value_extractor_unit_tb: self-checking bench for the key extractor
// Streams directed and random JSON documents through the block under many
// register settings; checks every word against a predictor or directed want.
// ----------------------------------------------------------------------------
module json_key_value_extractor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] item_index;
        logic        found;
        logic        bool_value;
        logic        run_last;
    } word_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  cfg_idx;
        logic [63:0] cfg_val;
        logic [7:0]  b;
        bit          last;
        bit          typed;
        word_t       want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // out_byte, item_index, found, bool_value, pad
    logic [1:0]  m_axis_tuser;  // kind
    logic        m_axis_tlast;

    json_key_value_extractor_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    // predictor registers
    logic [2:0]  r_mode;
    logic [4:0]  r_klen;
    logic [63:0] r_key0, r_key1;
    logic        r_fallb;

    // predictor walk state
    logic [3:0]  ph;
    logic [7:0]  win [18];
    int          since;
    int          od, idp;
    bit          oib, iib, instr, esc, fnd, bres, oend;
    int          items;
    int          lpos;
    logic [1:0]  walk;

    word_t       step_res [3];
    int          nres;
    word_t       pending_words [$];

    int          errors = 0;
    bit          quiet = 1'b0;
    logic [7:0]  doc [$];
    row_t        rows [$];

    function automatic void clear_walk();
        ph = jkv_pkg::P_SEARCH;
        foreach (win[i]) win[i] = 8'h00;
        since = 0; od = 0; idp = 0;
        oib = 0; iib = 0; instr = 0; esc = 0; fnd = 0; bres = 0; oend = 0;
        items = 0; lpos = 0; walk = jkv_pkg::W_TOP;
    endfunction

    function automatic void put(logic [1:0] k, logic [7:0] b, logic f, logic bv);
        if (nres < 3)
        begin
            step_res[nres] = '{k, b, items[15:0], f, bv, 1'b0};
            nres++;
        end
    endfunction

    function automatic void close_item();
        put(jkv_pkg::K_END, 8'h00, 1'b0, 1'b0);
        if (items < jkv_pkg::COUNT_MAX_DEF) items++;
    endfunction

    function automatic logic [7:0] needle_at(int i, int len);
        int k;
        logic [63:0] r;
        if (i == 0 || i + 1 == len) return jkv_pkg::C_QUOTE;
        k = (i - 1) & 15;
        r = (k < 8) ? r_key0 : r_key1;
        return r[8 * (k & 7) +: 8];
    endfunction

    function automatic void window_push(logic [7:0] c);
        int klen, len;
        klen = (r_klen > jkv_pkg::KEY_MAX_DEF) ? jkv_pkg::KEY_MAX_DEF : int'(r_klen);
        len = klen + 2;
        for (int i = 17; i > 0; i--) win[i] = win[i - 1];
        win[0] = c;
        if (since < 18) since++;
        if (since < len) return;
        for (int i = 0; i < len; i++)
            if (win[len - 1 - i] != needle_at(i, len)) return;
        ph = jkv_pkg::P_COLON;
    endfunction

    function automatic bit white(logic [7:0] c);
        return c == jkv_pkg::C_SP || c == jkv_pkg::C_TAB ||
               c == jkv_pkg::C_LF || c == jkv_pkg::C_CR;
    endfunction

    function automatic logic [7:0] unesc(logic [7:0] c);
        if (c == "n") return jkv_pkg::C_LF;
        if (c == "t") return jkv_pkg::C_TAB;
        if (c == "r") return jkv_pkg::C_CR;
        return c;
    endfunction

    function automatic void start_value(logic [7:0] c);
        ph = jkv_pkg::P_DONE;
        case (r_mode)
            jkv_pkg::M_STRING:
                if (c == jkv_pkg::C_QUOTE)
                begin
                    fnd = 1; instr = 1; ph = jkv_pkg::P_STR;
                end
            jkv_pkg::M_BOOL:
                if (c == "t")
                begin
                    ph = jkv_pkg::P_TRUE; lpos = 1;
                end
                else if (c == "f")
                begin
                    ph = jkv_pkg::P_FALSE; lpos = 1;
                end
            jkv_pkg::M_OBJECT:
                if (c == jkv_pkg::C_LBRC)
                begin
                    fnd = 1; od = 1; oib = 1;
                    put(jkv_pkg::K_BYTE, c, 1'b0, 1'b0);
                    ph = jkv_pkg::P_OBJ;
                end
            jkv_pkg::M_ARRAY:
                if (c == jkv_pkg::C_LBRK)
                begin
                    fnd = 1; od = 1; oib = 0; walk = jkv_pkg::W_TOP; ph = jkv_pkg::P_ARR;
                end
            jkv_pkg::M_EACH:
                if (c == jkv_pkg::C_LBRC || c == jkv_pkg::C_LBRK)
                begin
                    fnd = 1; od = 1; oib = (c == jkv_pkg::C_LBRC);
                    walk = jkv_pkg::W_TOP; ph = jkv_pkg::P_EACH;
                end
            default: ;
        endcase
    endfunction

    function automatic bit count_outer(logic [7:0] c);
        logic [7:0] op, cl;
        op = oib ? jkv_pkg::C_LBRC : jkv_pkg::C_LBRK;
        cl = oib ? jkv_pkg::C_RBRC : jkv_pkg::C_RBRK;
        if (oend) return 0;
        if (c == op && od < jkv_pkg::DEPTH_MAX_DEF) od++;
        else if (c == cl)
        begin
            if (od > 0) od--;
            if (od == 0)
            begin
                oend = 1;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic void count_inner(logic [7:0] c);
        logic [7:0] op, cl;
        op = iib ? jkv_pkg::C_LBRC : jkv_pkg::C_LBRK;
        cl = iib ? jkv_pkg::C_RBRC : jkv_pkg::C_RBRK;
        if (c == op && idp < jkv_pkg::DEPTH_MAX_DEF) idp++;
        else if (c == cl && idp > 0) idp--;
    endfunction

    function automatic void walk_byte(logic [7:0] c);
        bit was_in, was_esc, st;
        was_in = instr;
        was_esc = esc;
        case (ph)
            jkv_pkg::P_SEARCH:
            begin
                window_push(c);
                return;
            end
            jkv_pkg::P_COLON:
            begin
                if (white(c)) return;
                if (c == jkv_pkg::C_COLON)
                begin
                    ph = jkv_pkg::P_PRE;
                    return;
                end
                since = 0;
                ph = jkv_pkg::P_SEARCH;
                window_push(c);
                return;
            end
            jkv_pkg::P_PRE:
            begin
                if (!white(c)) start_value(c);
                return;
            end
            jkv_pkg::P_TRUE, jkv_pkg::P_FALSE:
            begin
                if (lpos >= ((ph == jkv_pkg::P_TRUE) ? 4 : 5) ||
                    c != jkv_pkg::lit_char(ph == jkv_pkg::P_TRUE, lpos[2:0]))
                begin
                    ph = jkv_pkg::P_DONE;
                    return;
                end
                lpos++;
                if (lpos == ((ph == jkv_pkg::P_TRUE) ? 4 : 5))
                begin
                    fnd = 1; bres = (ph == jkv_pkg::P_TRUE); ph = jkv_pkg::P_DONE;
                end
                return;
            end
            jkv_pkg::P_STR, jkv_pkg::P_OBJ, jkv_pkg::P_ARR, jkv_pkg::P_EACH: ;
            default: return;
        endcase

        if (instr)
        begin
            if (esc) esc = 0;
            else if (c == jkv_pkg::C_BSL) esc = 1;
            else if (c == jkv_pkg::C_QUOTE) instr = 0;
        end
        else if (c == jkv_pkg::C_QUOTE) instr = 1;
        st = !was_in && c != jkv_pkg::C_QUOTE;

        if (ph == jkv_pkg::P_STR)
        begin
            if (was_esc) put(jkv_pkg::K_BYTE, unesc(c), 0, 0);
            else if (c == jkv_pkg::C_QUOTE)
            begin
                close_item(); ph = jkv_pkg::P_DONE;
            end
            else if (c != jkv_pkg::C_BSL) put(jkv_pkg::K_BYTE, c, 0, 0);
        end
        else if (ph == jkv_pkg::P_OBJ)
        begin
            put(jkv_pkg::K_BYTE, c, 0, 0);
            if (st && count_outer(c))
            begin
                close_item(); ph = jkv_pkg::P_DONE;
            end
        end
        else if (ph == jkv_pkg::P_ARR)
        begin
            if (walk == jkv_pkg::W_TOP)
            begin
                if (!was_in && c == jkv_pkg::C_QUOTE) walk = jkv_pkg::W_STR;
                else if (st && (c == jkv_pkg::C_LBRC || c == jkv_pkg::C_LBRK))
                begin
                    walk = jkv_pkg::W_SKIP; idp = 1; iib = (c == jkv_pkg::C_LBRC);
                end
            end
            else if (walk == jkv_pkg::W_STR)
            begin
                if (was_esc) put(jkv_pkg::K_BYTE, unesc(c), 0, 0);
                else if (c == jkv_pkg::C_QUOTE)
                begin
                    close_item(); walk = jkv_pkg::W_TOP;
                end
                else if (c != jkv_pkg::C_BSL) put(jkv_pkg::K_BYTE, c, 0, 0);
            end
            else if (st)
            begin
                count_inner(c);
                if (idp == 0) walk = jkv_pkg::W_TOP;
            end
            if (st && count_outer(c)) ph = jkv_pkg::P_DONE;
        end
        else
        begin
            if (walk == jkv_pkg::W_TOP)
            begin
                if (st && c == jkv_pkg::C_LBRC)
                begin
                    put(jkv_pkg::K_BYTE, c, 0, 0);
                    walk = jkv_pkg::W_OBJ; idp = 1; iib = 1;
                end
            end
            else
            begin
                put(jkv_pkg::K_BYTE, c, 0, 0);
                if (st)
                begin
                    count_inner(c);
                    if (idp == 0)
                    begin
                        close_item();
                        walk = jkv_pkg::W_TOP;
                        if (oend) ph = jkv_pkg::P_DONE;
                    end
                end
            end
            if (st && count_outer(c) && walk != jkv_pkg::W_OBJ) ph = jkv_pkg::P_DONE;
        end
    endfunction

    function automatic void close_doc();
        logic bv;
        bv = 0;
        if (ph == jkv_pkg::P_STR || (ph == jkv_pkg::P_ARR && walk == jkv_pkg::W_STR))
        begin
            if (esc) put(jkv_pkg::K_BYTE, jkv_pkg::C_BSL, 0, 0);
            close_item();
        end
        else if (ph == jkv_pkg::P_OBJ || (ph == jkv_pkg::P_EACH && walk == jkv_pkg::W_OBJ))
            close_item();
        if (r_mode == jkv_pkg::M_BOOL) bv = fnd ? bres : r_fallb;
        put(jkv_pkg::K_FINAL, 8'h00, fnd, bv);
    endfunction

    // work out the result words one accepted byte causes
    function automatic void predict_byte(logic [7:0] c, bit last);
        nres = 0;
        if (c != 8'h00) walk_byte(c);
        if (c == 8'h00 || last)
        begin
            close_doc();
            clear_walk();
        end
        if (nres > 0) step_res[nres - 1].run_last = 1'b1;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result side: sample mid-cycle, the word moves at the next rising edge
    always @(negedge clk)
    begin
        word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_words.size() == 0)
                report("unexpected word", m_axis_tdata, 32'd0);
            else
            begin
                w = pending_words.pop_front();
                if (m_axis_tuser != w.kind)
                    report("kind", 32'(m_axis_tuser), 32'(w.kind));
                if (m_axis_tdata[7:0] != w.out_byte)
                    report("out_byte", 32'(m_axis_tdata[7:0]), 32'(w.out_byte));
                if (m_axis_tdata[23:8] != w.item_index)
                    report("item_index", 32'(m_axis_tdata[23:8]), 32'(w.item_index));
                if (m_axis_tdata[24] != w.found)
                    report("found", 32'(m_axis_tdata[24]), 32'(w.found));
                if (m_axis_tdata[25] != w.bool_value)
                    report("bool_value", 32'(m_axis_tdata[25]), 32'(w.bool_value));
                if (m_axis_tlast != w.run_last)
                    report("run_last", 32'(m_axis_tlast), 32'(w.run_last));
            end
        end
    end

    int stall = 0;
    always @(posedge clk)
    begin
        if (stall > 0)
        begin
            stall <= stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_byte(logic [7:0] b, bit last, bit typed, word_t want);
        bit acc;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do
        begin
            @(negedge clk);
            acc = s_axis_tready;
            @(posedge clk);
        end while (!acc);
        predict_byte(b, last);
        if (typed)
            pending_words.push_back(want);
        else
            for (int i = 0; i < nres; i++) pending_words.push_back(step_res[i]);
    endtask

    // hold the stream idle until every word is out, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            jkv_pkg::R_MODE:  r_mode = val[2:0];
            jkv_pkg::R_KLEN:  r_klen = val[4:0];
            jkv_pkg::R_KEY0:  r_key0 = val;
            jkv_pkg::R_KEY1:  r_key1 = val;
            jkv_pkg::R_FALLB: r_fallb = val[0];
            default: ;
        endcase
    endtask

    task automatic send_doc(bit zero_end);
        word_t none;
        none = '0;
        if (zero_end) doc.push_back(8'h00);
        foreach (doc[i])
            send_byte(doc[i], i == doc.size() - 1 && (!zero_end || $urandom_range(0, 1)),
                0, none);
        doc.delete();
    endtask

    function automatic void add_row(bit c, logic [2:0] idx, logic [63:0] v, logic [7:0] b,
                                    bit last, bit typed, word_t want);
        row_t r;
        r = '{c, idx, v, b, last, typed, want};
        rows.push_back(r);
    endfunction

    function automatic void add_text(string s, bit last_on_end);
        word_t none;
        none = '0;
        for (int i = 0; i < s.len(); i++)
            add_row(0, 3'd0, 64'd0, s[i], last_on_end && i == s.len() - 1, 0, none);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
    endfunction

    function automatic logic [7:0] any_nonzero();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void gen_string();
        int n;
        doc.push_back(jkv_pkg::C_QUOTE);
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    doc.push_back(jkv_pkg::C_BSL);
                    case ($urandom_range(0, 5))
                        0: doc.push_back("n");
                        1: doc.push_back("t");
                        2: doc.push_back("r");
                        3: doc.push_back(jkv_pkg::C_QUOTE);
                        4: doc.push_back(jkv_pkg::C_BSL);
                        default: doc.push_back(any_nonzero());
                    endcase
                end
                1, 2: doc.push_back(8'($urandom_range(8'h61, 8'h7A)));
                3:
                begin
                    logic [7:0] x;
                    x = any_nonzero();
                    doc.push_back((x == jkv_pkg::C_QUOTE || x == jkv_pkg::C_BSL) ? 8'h41 : x);
                end
                4:
                begin
                    case ($urandom_range(0, 3))
                        0: doc.push_back(jkv_pkg::C_LBRC);
                        1: doc.push_back(jkv_pkg::C_RBRC);
                        2: doc.push_back(jkv_pkg::C_LBRK);
                        default: doc.push_back(jkv_pkg::C_RBRK);
                    endcase
                end
                default: doc.push_back(jkv_pkg::C_SP);
            endcase
        end
        if ($urandom_range(0, 7) != 0) doc.push_back(jkv_pkg::C_QUOTE);
    endfunction

    function automatic void gen_value(int depth, int shape);
        int n;
        case (shape)
            0: gen_string();
            1:
                case ($urandom_range(0, 4))
                    0, 1: push_text("true");
                    2: push_text("false");
                    3: push_text("fa");
                    default: push_text("trx");
                endcase
            2, 3:
            begin
                doc.push_back(shape == 2 ? jkv_pkg::C_LBRC : jkv_pkg::C_LBRK);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0) doc.push_back(",");
                    if (shape == 2)
                    begin
                        gen_string();
                        doc.push_back(jkv_pkg::C_COLON);
                    end
                    gen_value(depth + 1, depth < 2 ? int'($urandom_range(0, 4)) : 0);
                end
                if ($urandom_range(0, 9) != 0)
                    doc.push_back(shape == 2 ? jkv_pkg::C_RBRC : jkv_pkg::C_RBRK);
            end
            default:
                repeat ($urandom_range(1, 3)) doc.push_back(8'($urandom_range(8'h30, 8'h39)));
        endcase
    endfunction

    // one random document around the configured key
    function automatic void gen_doc(logic [7:0] key [16], int klen);
        repeat ($urandom_range(0, 4)) doc.push_back(any_nonzero());
        if ($urandom_range(0, 7) != 0)
        begin
            doc.push_back(jkv_pkg::C_QUOTE);
            for (int i = 0; i < klen; i++) doc.push_back(key[i]);
            doc.push_back(jkv_pkg::C_QUOTE);
            repeat ($urandom_range(0, 2)) doc.push_back(jkv_pkg::C_SP);
            if ($urandom_range(0, 7) == 0) doc.push_back(",");
            doc.push_back(jkv_pkg::C_COLON);
            repeat ($urandom_range(0, 2))
                doc.push_back($urandom_range(0, 1) ? jkv_pkg::C_TAB : jkv_pkg::C_LF);
        end
        gen_value(0, ($urandom_range(0, 3) != 0) ? (r_mode == jkv_pkg::M_EACH ?
            int'($urandom_range(2, 3)) : (r_mode < 3'd4 ? int'(r_mode) : 4))
            : int'($urandom_range(0, 4)));
        repeat ($urandom_range(0, 3)) doc.push_back(any_nonzero());
    endfunction

    initial
    begin
        #50ms;
        $display("json_key_value_extractor_unit_tb: errors");
        $finish;
    end

    initial
    begin
        word_t       w;
        logic [7:0]  key [16];
        logic [63:0] k0, k1;
        int          klen, sent;
        logic [4:0]  klen_reg;

        r_mode = jkv_pkg::M_STRING; r_klen = 0; r_key0 = 0; r_key1 = 0; r_fallb = 0;
        clear_walk();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: reset values, fallback, bool, object, string, extremes
        w = '{jkv_pkg::K_FINAL, 8'h00, 16'h0, 1'b0, 1'b0, 1'b1};
        add_row(0, 3'd0, 64'd0, 8'h00, 0, 1, w);
        add_row(1, jkv_pkg::R_FALLB, 64'h1, 8'h00, 0, 0, w);
        add_row(1, jkv_pkg::R_MODE, 64'(jkv_pkg::M_BOOL), 8'h00, 0, 0, w);
        w = '{jkv_pkg::K_FINAL, 8'h00, 16'h0, 1'b0, 1'b1, 1'b1};
        add_row(0, 3'd0, 64'd0, "x", 1, 1, w);
        add_text("\"\":true", 1);
        add_row(1, jkv_pkg::R_MODE, 64'(jkv_pkg::M_OBJECT), 8'h00, 0, 0, w);
        add_text("\"\":{}", 1);
        add_row(1, jkv_pkg::R_MODE, 64'(jkv_pkg::M_STRING), 8'h00, 0, 0, w);
        add_text("\"\":\"\\", 0);
        add_row(0, 3'd0, 64'd0, 8'hFF, 0, 0, w);
        add_text("\\", 1);
        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                drain();
                write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            end
            else
                send_byte(rows[i].b, rows[i].last, rows[i].typed, rows[i].want);
        end

        // random part: each phase sets every register, then streams one document
        sent = 0;
        for (int p = 0; p < 12; p++)
        begin
            quiet = (p >= 9);
            case (p % 5)
                0: klen_reg = 5'd0;
                1: klen_reg = 5'd16;
                2: klen_reg = 5'd31;
                default: klen_reg = 5'($urandom_range(1, 6));
            endcase
            klen = (klen_reg > jkv_pkg::KEY_MAX_DEF) ? jkv_pkg::KEY_MAX_DEF : int'(klen_reg);
            for (int i = 0; i < 16; i++)
                key[i] = ($urandom_range(0, 19) == 0) ?
                         (($urandom_range(0, 1)) ? 8'h00 : jkv_pkg::C_QUOTE)
                         : 8'($urandom_range(8'h61, 8'h7A));
            for (int i = 0; i < 8; i++)
            begin
                k0[8 * i +: 8] = key[i];
                k1[8 * i +: 8] = key[i + 8];
            end
            drain();
            write_reg(jkv_pkg::R_MODE, (p < 8) ? 64'(p) : 64'($urandom_range(0, 4)));
            write_reg(jkv_pkg::R_KLEN, 64'(klen_reg));
            write_reg(jkv_pkg::R_KEY0, k0);
            write_reg(jkv_pkg::R_KEY1, k1);
            write_reg(jkv_pkg::R_FALLB, 64'($urandom_range(0, 1)));
            gen_doc(key, klen);
            sent += doc.size();
            send_doc($urandom_range(0, 3) == 0);
            if (sent > 150) break;
        end

        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("json_key_value_extractor_unit_tb: clean");
        else
            $display("json_key_value_extractor_unit_tb: errors");
        $finish;
    end

endmodule

### json_key_value_extractor_unit.f
hw/rtl/jkv_pkg.sv
hw/rtl/jkv_match_cell.sv
hw/rtl/jkv_value_walk.sv
hw/rtl/json_key_value_extractor_unit.sv
tb/sv/json_key_value_extractor_unit_tb.sv
